// File: hw/rtl/wvd_pkg.sv
// ----------------------------------------------------------------------------
// wvd_pkg
// Types and constants shared by the vertex deduplication unit.
// ----------------------------------------------------------------------------
package wvd_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned SLOTS_DEF = 2048;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned KEY_W = 256;
	localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

	typedef struct packed {
		logic start_of_mesh;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] welded_index;
		logic is_new;
		logic table_full;
	} out_item_t;

	// FNV-1a step over one byte. The prime has only bits 40, 8, 7, 5, 4, 1
	// and 0 set, so the product is a sum of shifted copies.
	function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = h ^ {56'd0, b};
			fnv_byte = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8)
				+ (x << 40);
		end
	endfunction

endpackage

// File: hw/rtl/wvd_front.sv
// ----------------------------------------------------------------------------
// wvd_front
// Accepts and hashes keys one byte a cycle into a 2-entry queue; full stalls.
// ----------------------------------------------------------------------------
module wvd_front #(
	parameter int unsigned SLOTS = wvd_pkg::SLOTS_DEF,
	parameter int unsigned SLOT_W = $clog2(SLOTS)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wvd_pkg::in_item_t in_data,
	output logic q_valid,
	input logic q_ready,
	output wvd_pkg::in_item_t q_item,
	output logic [SLOT_W-1:0] q_slot
);

	wvd_pkg::in_item_t item_q;
	logic [63:0] hash_q;
	logic [4:0] byte_q;
	logic busy_q;
	logic [31:0] word;
	logic [7:0] cur_byte;
	logic [63:0] h_next;
	wvd_pkg::in_item_t qi_q [2];
	logic [SLOT_W-1:0] qs_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	always_comb begin
		case (byte_q[4:2])
			3'd0: word = item_q.pos_x;
			3'd1: word = item_q.pos_y;
			3'd2: word = item_q.pos_z;
			3'd3: word = item_q.norm_x;
			3'd4: word = item_q.norm_y;
			3'd5: word = item_q.norm_z;
			3'd6: word = item_q.tex_u;
			default: word = item_q.tex_v;
		endcase
		case (byte_q[1:0])
			2'd0: cur_byte = word[7:0];
			2'd1: cur_byte = word[15:8];
			2'd2: cur_byte = word[23:16];
			default: cur_byte = word[31:24];
		endcase
		h_next = wvd_pkg::fnv_byte(hash_q, cur_byte);
	end

	assign in_ready = !busy_q;
	assign push = busy_q && byte_q == 5'd31 && cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_item = qi_q[rd_q];
	assign q_slot = qs_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			byte_q <= 5'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				byte_q <= 5'd0;
			end else if (busy_q && byte_q != 5'd31) begin
				byte_q <= byte_q + 5'd1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			if (push) wr_q <= !wr_q;
			if (q_valid && q_ready) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_valid && q_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
			hash_q <= wvd_pkg::FNV_OFFSET;
		end else if (busy_q && byte_q != 5'd31) begin
			hash_q <= h_next;
		end
		if (push) begin
			qi_q[wr_q] <= item_q;
			qs_q[wr_q] <= SLOT_W'(h_next % 64'(SLOTS));
		end
	end

endmodule

// File: hw/rtl/wvd_back.sv
// ----------------------------------------------------------------------------
// wvd_back
// Probes the slot table, compares stored keys and appends new vertices.
// ----------------------------------------------------------------------------
module wvd_back #(
	parameter int unsigned CAPACITY = wvd_pkg::CAPACITY_DEF,
	parameter int unsigned SLOTS = wvd_pkg::SLOTS_DEF,
	parameter int unsigned SLOT_W = $clog2(SLOTS),
	parameter int unsigned VTX_W = $clog2(CAPACITY)
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input wvd_pkg::in_item_t q_item,
	input logic [SLOT_W-1:0] q_slot,
	output logic out_valid,
	input logic out_ready,
	output wvd_pkg::out_item_t out_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_READ = 6'b000100,
		ST_KEY = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned PRB_W = $clog2(SLOTS + 1);

	state_t state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRB_W-1:0] probes_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] clr_q;
	logic pend_q;
	logic [wvd_pkg::KEY_W-1:0] key_q;
	logic used_mem [SLOTS];
	logic [VTX_W-1:0] vtx_mem [SLOTS];
	logic [wvd_pkg::KEY_W-1:0] key_mem [CAPACITY];
	logic [VTX_W-1:0] vtx_rd;
	logic [wvd_pkg::KEY_W-1:0] key_rd;
	logic used_rd;
	wvd_pkg::out_item_t res_q;
	logic ovalid_q;
	logic wr_new;

	assign q_ready = state_q == ST_IDLE && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data = res_q;
	assign wr_new = state_q == ST_CHECK && !used_rd && count_q < CNT_W'(CAPACITY);

	always_ff @(posedge clk) begin
		used_rd <= used_mem[slot_q];
		vtx_rd <= vtx_mem[slot_q];
		key_rd <= key_mem[vtx_rd];
		if (state_q == ST_CLEAR) begin
			used_mem[clr_q] <= 1'b0;
		end else if (wr_new) begin
			used_mem[slot_q] <= 1'b1;
		end
		if (wr_new) begin
			vtx_mem[slot_q] <= count_q[VTX_W-1:0];
			key_mem[count_q[VTX_W-1:0]] <= key_q;
		end
		if (q_valid && q_ready) begin
			key_q <= {q_item.tex_v, q_item.tex_u, q_item.norm_z, q_item.norm_y,
				q_item.norm_x, q_item.pos_z, q_item.pos_y, q_item.pos_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			count_q <= '0;
			ovalid_q <= 1'b0;
			slot_q <= '0;
			probes_q <= '0;
			clr_q <= '0;
			pend_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_valid && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						slot_q <= q_slot;
						probes_q <= '0;
						if (q_item.start_of_mesh) begin
							count_q <= '0;
							clr_q <= '0;
							pend_q <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_KEY;
				end
				ST_KEY: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!used_rd) begin
						if (wr_new) begin
							count_q <= count_q + 1'b1;
							res_q <= '{welded_index: wvd_pkg::IDX_W'(count_q), is_new: 1'b1,
								table_full: 1'b0};
						end else begin
							res_q <= '{welded_index: '0, is_new: 1'b0, table_full: 1'b1};
						end
						state_q <= ST_DONE;
					end else if (key_rd == key_q) begin
						res_q <= '{welded_index: wvd_pkg::IDX_W'(vtx_rd), is_new: 1'b0,
							table_full: 1'b0};
						state_q <= ST_DONE;
					end else if (probes_q == PRB_W'(SLOTS - 1)) begin
						res_q <= '{welded_index: '0, is_new: 1'b0, table_full: 1'b1};
						state_q <= ST_DONE;
					end else begin
						probes_q <= probes_q + 1'b1;
						slot_q <= (slot_q == SLOT_W'(SLOTS - 1)) ? '0 : slot_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						pend_q <= 1'b0;
						state_q <= pend_q ? ST_READ : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/weld_vertices_dedup_unit.sv
// ----------------------------------------------------------------------------
// weld_vertices_dedup_unit
// Hash-based vertex welding: maps each vertex key to a unique vertex index.
// ----------------------------------------------------------------------------
// A key is hashed one byte a cycle, the last byte waiting while the queue is
// full, and in_ready stays low from each transfer until the key is pushed
// into the queue, so the front end never takes a new key before it is done
// with the last one. The back end takes each probe of the slot table through
// ST_READ (slot read), ST_KEY (key read) and ST_CHECK (compare), repeating
// them for each further probe, and posts the result from ST_DONE. After
// reset, and for every key flagged as a start of mesh, the back end first
// clears all SLOTS entries of the slot table (2048 by default).
module weld_vertices_dedup_unit #(
	parameter int unsigned CAPACITY = wvd_pkg::CAPACITY_DEF,
	parameter int unsigned SLOTS = wvd_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wvd_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output wvd_pkg::out_item_t out_data
);

	localparam int unsigned SLOT_W = $clog2(SLOTS);

	logic q_valid, q_ready;
	wvd_pkg::in_item_t q_item;
	logic [SLOT_W-1:0] q_slot;

	wvd_front #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid, .q_ready, .q_item, .q_slot
	);

	wvd_back #(.CAPACITY(CAPACITY), .SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item, .q_slot,
		.out_valid, .out_ready, .out_data
	);

endmodule

// File: hw/rtl/wvd_checker.sv
// ----------------------------------------------------------------------------
// wvd_checker
// Port-level checks for the vertex welding unit.
// ----------------------------------------------------------------------------
module wvd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input wvd_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result changed while stalled.");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.is_new && out_data.table_full))
		else $error("New and full flagged together.");

	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |-> out_data.welded_index == '0)
		else $error("Full result carries an index.");

	a_hash_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Front end took a key while hashing.");

endmodule

bind weld_vertices_dedup_unit wvd_checker u_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
